/* src/ppc_pkg.sv */
// Shared constants, types and the sine table of the plasma pixel color generator.
package ppc_pkg;

    localparam int PIX_X_W   = 8;
    localparam int PIX_Y_W   = 6;
    localparam int DRIFT_W   = 16;
    localparam int COLOR_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int C1X_W = 7;
    localparam int C1Y_W = 7;
    localparam int C3X_W = 8;
    localparam int C3Y_W = 5;

    localparam logic [C1X_W-1:0] C1X_RESET = 7'd64;
    localparam logic [C1Y_W-1:0] C1Y_RESET = 7'd64;
    localparam logic [C3X_W-1:0] C3X_RESET = 8'd96;
    localparam logic [C3Y_W-1:0] C3Y_RESET = 5'd0;

    // Fixed centers of the second and fourth terms.
    localparam logic [16:0] CTR2_X = 17'd64;
    localparam logic [16:0] CTR2_Y = 17'd64;
    localparam logic [16:0] CTR4_X = 17'd192;
    localparam logic [16:0] CTR4_Y = 17'd100;

    localparam int NUM_TERMS = 4;
    localparam int DIFF_W    = 17;
    localparam int SQ_W      = 34;
    localparam int RAD_W     = 50;
    localparam int ROOT_W    = 25;
    localparam int FRAC_SH   = 16;

    localparam int SINE_DEPTH = 1024;
    localparam int IDX_W      = $clog2(SINE_DEPTH);
    localparam int SINE_W     = 16;
    localparam int PHASE_SH   = 24;

    localparam longint unsigned PHASE_NUM = 64'(SINE_DEPTH) * 64'd65536 * 64'd1000000;
    localparam int K_W = 21;
    localparam logic [K_W-1:0] PHASE_K8 = K_W'(PHASE_NUM / (64'd6283185 * 64'd8));
    localparam logic [K_W-1:0] PHASE_K7 = K_W'(PHASE_NUM / (64'd6283185 * 64'd7));

    localparam longint unsigned Q30_ONE    = 64'd1073741824;
    localparam longint unsigned TWOPI_Q30  = 64'd6746518852;
    localparam longint unsigned PI_Q30     = 64'd3373259426;
    localparam longint unsigned HALFPI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C1X = 2'd0,
        CFG_C1Y = 2'd1,
        CFG_C3X = 2'd2,
        CFG_C3Y = 2'd3
    } t_cfg_idx;

    typedef logic signed [SINE_W-1:0] t_sine_rom [SINE_DEPTH];

    // Sine of entry i in Q1.14, from a Q30 Taylor series on the folded angle.
    function automatic logic signed [SINE_W-1:0] sine_val(input int unsigned i);
        longint unsigned a;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        bit neg;
        a = (64'(i) * TWOPI_Q30) / SINE_DEPTH;
        neg = 1'b0;
        if (a >= PI_Q30) begin
            neg = 1'b1;
            a = a - PI_Q30;
        end
        if (a > HALFPI_Q30) begin
            a = (a <= PI_Q30) ? (PI_Q30 - a) : 64'd0;
        end
        x2 = (a * a) >> 30;
        t = Q30_ONE;
        t = Q30_ONE - ((x2 * t) >> 30) / 110;
        t = Q30_ONE - ((x2 * t) >> 30) / 72;
        t = Q30_ONE - ((x2 * t) >> 30) / 42;
        t = Q30_ONE - ((x2 * t) >> 30) / 20;
        t = Q30_ONE - ((x2 * t) >> 30) / 6;
        s = (a * t) >> 30;
        s = (s + 64'd32768) >> 16;
        return neg ? -SINE_W'(s) : SINE_W'(s);
    endfunction

    function automatic t_sine_rom sine_rom_init();
        t_sine_rom rom;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            rom[i] = sine_val(i);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = sine_rom_init();

endpackage

/* src/ppc_pix_if.sv */
// Pixel input channel: position and drift offsets with a valid/ready handshake.
interface ppc_pix_if;
    logic                           valid;
    logic                           ready;
    logic [ppc_pkg::PIX_X_W-1:0]    pixel_x;
    logic [ppc_pkg::PIX_Y_W-1:0]    pixel_y;
    logic [ppc_pkg::DRIFT_W-1:0]    x_drift;
    logic [ppc_pkg::DRIFT_W-1:0]    y_drift;

    modport source (output valid, output pixel_x, output pixel_y, output x_drift,
                    output y_drift, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, input x_drift,
                  input y_drift, output ready);
endinterface

/* src/ppc_color_if.sv */
// Color output channel: one gray level per transfer.
interface ppc_color_if;
    logic                           valid;
    logic                           ready;
    logic [ppc_pkg::COLOR_W-1:0]    pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink (input valid, input pixel_color, output ready);
endinterface

/* src/plasma_pixel_color.sv */
// Stages in order: absolute differences, squares, radicand, square root, phase index,
// sine lookup and the output register. One pixel per cycle while the output is not
// stalled; 25 of the stages are the bit-per-stage square root. Each stage holds its
// item while the stages after it are full, so bubbles close up and a waiting result
// does not block new input transfers until every stage is full. Reset clears every
// stage valid bit and loads the centers with their reset values; payload is not reset.
module plasma_pixel_color (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    ppc_pix_if.sink                         i_pix,
    ppc_color_if.source                     o_color,
    input  logic                            i_cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ppc_pkg::*;

    localparam int ST_A = 0;
    localparam int ST_B = 1;
    localparam int ST_C = 2;
    localparam int ST_R = 3;
    localparam int ST_M = ST_R + ROOT_W;
    localparam int ST_T = ST_M + 1;
    localparam int ST_O = ST_T + 1;
    localparam int NST  = ST_O + 1;

    logic [C1X_W-1:0] r_c1x;
    logic [C1Y_W-1:0] r_c1y;
    logic [C3X_W-1:0] r_c3x;
    logic [C3Y_W-1:0] r_c3y;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] en;

    logic [DIFF_W-1:0]   r_adx  [NUM_TERMS];
    logic [DIFF_W-1:0]   r_ady  [NUM_TERMS];
    logic [SQ_W-1:0]     r_sqx  [NUM_TERMS];
    logic [SQ_W-1:0]     r_sqy  [NUM_TERMS];
    logic [RAD_W-1:0]    r_rem  [ROOT_W+1][NUM_TERMS];
    logic [ROOT_W-1:0]   r_root [ROOT_W+1][NUM_TERMS];
    logic [IDX_W-1:0]    r_idx  [NUM_TERMS];
    logic signed [SINE_W-1:0] r_sin [NUM_TERMS];
    logic [COLOR_W-1:0]  r_color;

    logic [DIFF_W-1:0] px [NUM_TERMS];
    logic [DIFF_W-1:0] py [NUM_TERMS];
    logic [DIFF_W-1:0] cx [NUM_TERMS];
    logic [DIFF_W-1:0] cy [NUM_TERMS];
    logic [K_W-1:0]    kk [NUM_TERMS];
    logic signed [SINE_W+2:0] n_sum;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [DIFF_W-1:0] a,
                                                    input logic [DIFF_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1x <= C1X_RESET;
            r_c1y <= C1Y_RESET;
            r_c3x <= C3X_RESET;
            r_c3y <= C3Y_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_C1X: r_c1x <= i_cfg_data[C1X_W-1:0];
                CFG_C1Y: r_c1y <= i_cfg_data[C1Y_W-1:0];
                CFG_C3X: r_c3x <= i_cfg_data[C3X_W-1:0];
                CFG_C3Y: r_c3y <= i_cfg_data[C3Y_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it or any stage after it is empty, or when the output is ready.
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            en[k] = o_color.ready || !(&(r_vld | NST'((64'd1 << k) - 64'd1)));
        end
    end

    assign i_pix.ready   = en[ST_A];
    assign o_color.valid = r_vld[ST_O];
    assign o_color.pixel_color = r_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_pix.valid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // Points, centers and phase constants of the four terms.
    always_comb begin
        px[0] = DIFF_W'(i_pix.pixel_x) + DIFF_W'(i_pix.x_drift);
        py[0] = DIFF_W'(i_pix.pixel_y);
        cx[0] = DIFF_W'(r_c1x);
        cy[0] = DIFF_W'(r_c1y);
        px[1] = DIFF_W'(i_pix.pixel_x);
        py[1] = DIFF_W'(i_pix.pixel_y);
        cx[1] = CTR2_X;
        cy[1] = CTR2_Y;
        px[2] = DIFF_W'(i_pix.pixel_x);
        py[2] = DIFF_W'(i_pix.pixel_y) + DIFF_W'(i_pix.y_drift);
        cx[2] = DIFF_W'(r_c3x);
        cy[2] = DIFF_W'(r_c3y);
        px[3] = DIFF_W'(i_pix.pixel_x);
        py[3] = DIFF_W'(i_pix.pixel_y);
        cx[3] = CTR4_X;
        cy[3] = CTR4_Y;
        kk[0] = PHASE_K8;
        kk[1] = PHASE_K8;
        kk[2] = PHASE_K7;
        kk[3] = PHASE_K8;
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < NUM_TERMS; t++) begin
            if (en[ST_A]) begin
                r_adx[t] <= abs_diff(px[t], cx[t]);
                r_ady[t] <= abs_diff(py[t], cy[t]);
            end
            if (en[ST_B]) begin
                r_sqx[t] <= SQ_W'(r_adx[t]) * SQ_W'(r_adx[t]);
                r_sqy[t] <= SQ_W'(r_ady[t]) * SQ_W'(r_ady[t]);
            end
            if (en[ST_C]) begin
                r_rem[0][t]  <= RAD_W'(r_sqx[t] + r_sqy[t]) << FRAC_SH;
                r_root[0][t] <= '0;
            end
        end
    end

    // Square root, one result bit per stage, most significant bit first.
    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - j;
        logic [RAD_W-1:0] cand [NUM_TERMS];

        always_comb begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                cand[t] = (RAD_W'(r_root[j][t]) << (B + 1)) | (RAD_W'(1) << (2 * B));
            end
        end

        always_ff @(posedge i_clk) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                if (en[ST_R + j]) begin
                    if (r_rem[j][t] >= cand[t]) begin
                        r_rem[j+1][t]  <= r_rem[j][t] - cand[t];
                        r_root[j+1][t] <= r_root[j][t] | (ROOT_W'(1) << B);
                    end else begin
                        r_rem[j+1][t]  <= r_rem[j][t];
                        r_root[j+1][t] <= r_root[j][t];
                    end
                end
            end
        end
    end

    // Phase index, sine lookup and the color.
    always_comb begin
        n_sum = '0;
        for (int t = 0; t < NUM_TERMS; t++) begin
            n_sum = n_sum + (SINE_W+3)'(r_sin[t]);
        end
        n_sum = n_sum + (SINE_W+3)'(65536);
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < NUM_TERMS; t++) begin
            if (en[ST_M]) begin
                r_idx[t] <= IDX_W'(((ROOT_W+K_W)'(r_root[ROOT_W][t]) *
                                    (ROOT_W+K_W)'(kk[t])) >> PHASE_SH);
            end
            if (en[ST_T]) begin
                r_sin[t] <= SINE_ROM[r_idx[t]];
            end
        end
        if (en[ST_O]) begin
            r_color <= {n_sum[16:14], 1'b0};
        end
    end

    // Stalls can only start at the output register.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_vld[ST_O] && !o_color.ready))
        else $error("input stalled while output side is free");

    a_color_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_color.valid |-> !o_color.pixel_color[0])
        else $error("odd color produced");

    a_rad_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_C] |-> (r_rem[0][0][FRAC_SH-1:0] == '0 && r_root[0][0] == '0))
        else $error("square root input malformed");

    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_T] && en[ST_O]) |=> r_vld[ST_O])
        else $error("item lost before output register");

endmodule
